// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  `ASSERT_PROP(lbl, clk, rstn, !(prop))
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ===== rtl/sbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// sbpa_pkg
// shared widths, codes and cell control types of the block pool allocator
// ----------------------------------------------------------------------------
package sbpa_pkg;

  localparam int SIZE_W = 16;
  localparam int BASE_W = 22;
  localparam int IDX_W  = 6;
  localparam int ST_W   = 3;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_SIZE   = 3'd1;
  localparam logic [ST_W-1:0] ST_ALL_BUSY  = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_UNKNOWN   = 3'd4;
  localparam logic [ST_W-1:0] ST_LOAD_BUSY = 3'd5;

  typedef struct packed {
    logic              cap;
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] sz;
    logic [BASE_W-1:0] off;
    logic              do_load;
    logic              do_alloc;
    logic              do_rel;
    logic [SIZE_W-1:0] new_sz;
    logic [BASE_W-1:0] new_base;
  } cell_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] size;
    logic [BASE_W-1:0] base;
  } cell_link_t;

endpackage

// ===== rtl/sbpa_cell.sv =====
// ----------------------------------------------------------------------------
// sbpa_cell
// one table entry: compares against a request and shifts on insertion
// ----------------------------------------------------------------------------
module sbpa_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbpa_pkg::cell_ctrl_t ctrl_i,
  input  sbpa_pkg::cell_link_t prev_i,
  input  logic                 take_i,
  output sbpa_pkg::cell_link_t link_o,
  output logic                 match_o,
  output logic                 seen_o,
  output logic                 busy_o
);

  logic                        valid_q, valid_d;
  logic                        busy_q, busy_d;
  logic [sbpa_pkg::SIZE_W-1:0] size_q, size_d;
  logic [sbpa_pkg::BASE_W-1:0] base_q, base_d;
  logic                        match_q, match_d;
  logic                        size_eq;

  assign size_eq = valid_q && (size_q == ctrl_i.sz);

  always_comb begin
    match_d = match_q;
    if (ctrl_i.cap) begin
      case (ctrl_i.op)
        sbpa_pkg::OP_LOAD:    match_d = !(valid_q && (size_q <= ctrl_i.sz));
        sbpa_pkg::OP_ALLOC:   match_d = size_eq && !busy_q;
        sbpa_pkg::OP_RELEASE: match_d = valid_q && busy_q && (base_q == ctrl_i.off);
        default:              match_d = 1'b0;
      endcase
    end
  end

  always_comb begin
    valid_d = valid_q;
    busy_d  = busy_q;
    size_d  = size_q;
    base_d  = base_q;
    if (ctrl_i.do_load && match_q) begin
      valid_d = prev_i.valid;
      busy_d  = 1'b0;
      if (take_i) begin
        size_d = ctrl_i.new_sz;
        base_d = ctrl_i.new_base;
      end else begin
        size_d = prev_i.size;
        base_d = prev_i.base + {{(sbpa_pkg::BASE_W-sbpa_pkg::SIZE_W){1'b0}}, ctrl_i.new_sz};
      end
    end else if (ctrl_i.do_alloc && take_i) begin
      busy_d = 1'b1;
    end else if (ctrl_i.do_rel && take_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      busy_q  <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      busy_q  <= busy_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    base_q  <= base_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.size  = size_q;
  assign link_o.base  = base_q;
  assign match_o      = match_q;
  assign seen_o       = size_eq;
  assign busy_o       = busy_q;

endmodule

// ===== rtl/sized_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// sized_block_pool_allocator
// sorted table of fixed block sizes with allocate and release by base offset
// ----------------------------------------------------------------------------
// Input channel in_valid_i / in_stall_o carries op_i, block_size_i, offset_i;
// output channel out_valid_o / out_stall_i carries status_o,
// granted_offset_o and entry_index_o, one result transaction per input.
// op 0 inserts a size into the sorted table, op 1 grants the lowest free
// entry of an exact size, op 2 frees the busy entry at a base offset.
// Each entry lives in a cell of a chain; on insertion cells past the
// insertion point take their neighbor's entry and add the new size to it.
// Timing: in the accept cycle every cell compares the request; the pick
// step then picks the lowest matching cell, updates the chain and loads
// the output register. The next transaction is accepted only after the
// pick of the previous one.
// A result waiting under out_stall_i does not block the next accept; the
// pick of that next transaction waits until the output register is free.
// Reset empties the table and frees all entries at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sized_block_pool_allocator #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sbpa_pkg::OP_W-1:0]     op_i,
  input  logic [sbpa_pkg::SIZE_W-1:0]   block_size_i,
  input  logic [sbpa_pkg::BASE_W-1:0]   offset_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sbpa_pkg::ST_W-1:0]     status_o,
  output logic [sbpa_pkg::BASE_W-1:0]   granted_offset_o,
  output logic [sbpa_pkg::IDX_W-1:0]    entry_index_o
);

  localparam int N  = MAX_BLOCKS;
  localparam int IW = sbpa_pkg::IDX_W;
  localparam int BW = sbpa_pkg::BASE_W;
  localparam int SW = sbpa_pkg::SIZE_W;

  sbpa_pkg::cell_ctrl_t ctrl;
  sbpa_pkg::cell_link_t link_w [N];
  sbpa_pkg::cell_link_t prev_w [N];

  logic [N-1:0] match_w, seen_w, busy_w, valid_w, take_w;

  logic                      pend_q, pend_d;
  logic [sbpa_pkg::OP_W-1:0] op_q;
  logic [SW-1:0]             sz_q;
  logic                      any_busy_q, seen_q;
  logic [BW-1:0]             total_q, total_d;
  logic                      out_valid_q, out_valid_d;
  logic [sbpa_pkg::ST_W-1:0] status_q, status_d;
  logic [BW-1:0]             grant_q, grant_d;
  logic [IW-1:0]             index_q, index_d;

  logic          accept, commit, any_match, ld_ok, pick_valid;
  logic [BW-1:0] pick_base;
  logic [IW-1:0] pick_idx;

  assign accept = in_valid_i && !pend_q;
  assign commit = pend_q && (!out_valid_q || !out_stall_i);

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign prev_w[gi] = '{valid: 1'b1, size: '0, base: '0};
      end else begin : g_rest
        assign prev_w[gi] = link_w[gi-1];
      end
      sbpa_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .prev_i  (prev_w[gi]),
        .take_i  (take_w[gi]),
        .link_o  (link_w[gi]),
        .match_o (match_w[gi]),
        .seen_o  (seen_w[gi]),
        .busy_o  (busy_w[gi])
      );
      assign valid_w[gi] = link_w[gi].valid;
    end
  endgenerate

  // lowest set match bit
  assign take_w    = match_w & (~match_w + {{(N-1){1'b0}}, 1'b1});
  assign any_match = |match_w;

  always_comb begin
    pick_base  = '0;
    pick_idx   = '0;
    pick_valid = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (take_w[i]) begin
        pick_idx = pick_idx | IW'(i);
        if (valid_w[i]) begin
          pick_base  = pick_base | link_w[i].base;
          pick_valid = 1'b1;
        end
      end
    end
  end

  assign ld_ok = (op_q == sbpa_pkg::OP_LOAD) && !any_busy_q && !valid_w[N-1];

  always_comb begin
    ctrl.cap      = accept;
    ctrl.op       = op_i;
    ctrl.sz       = block_size_i;
    ctrl.off      = offset_i;
    ctrl.do_load  = commit && ld_ok;
    ctrl.do_alloc = commit && (op_q == sbpa_pkg::OP_ALLOC) && any_match;
    ctrl.do_rel   = commit && (op_q == sbpa_pkg::OP_RELEASE) && any_match;
    ctrl.new_sz   = sz_q;
    ctrl.new_base = pick_valid ? pick_base : total_q;
  end

  always_comb begin
    status_d = sbpa_pkg::ST_OK;
    grant_d  = '0;
    index_d  = '0;
    case (op_q)
      sbpa_pkg::OP_LOAD: begin
        if (any_busy_q) begin
          status_d = sbpa_pkg::ST_LOAD_BUSY;
        end else if (valid_w[N-1]) begin
          status_d = sbpa_pkg::ST_FULL;
        end else begin
          grant_d = ctrl.new_base;
          index_d = pick_idx;
        end
      end
      sbpa_pkg::OP_ALLOC: begin
        if (any_match) begin
          grant_d = pick_base;
          index_d = pick_idx;
        end else begin
          status_d = seen_q ? sbpa_pkg::ST_ALL_BUSY : sbpa_pkg::ST_NO_SIZE;
        end
      end
      sbpa_pkg::OP_RELEASE: begin
        if (any_match) begin
          grant_d = pick_base;
          index_d = pick_idx;
        end else begin
          status_d = sbpa_pkg::ST_UNKNOWN;
        end
      end
      default: begin
        status_d = sbpa_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (commit) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    total_d = total_q;
    if (ctrl.do_load) begin
      total_d = total_q + {{(BW-SW){1'b0}}, sz_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_i;
      sz_q       <= block_size_i;
      any_busy_q <= |busy_w;
      seen_q     <= |seen_w;
    end
    if (commit) begin
      status_q <= status_d;
      grant_q  <= grant_d;
      index_q  <= index_d;
    end
  end

  assign in_stall_o       = pend_q;
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_offset_o = grant_q;
  assign entry_index_o    = index_q;

  `ASSERT_PROP(a_valid_therm, clk_i, rst_ni, ((valid_w + {{(N-1){1'b0}}, 1'b1}) & valid_w) == '0)
  `ASSERT_NEVER(a_busy_unused, clk_i, rst_ni, (busy_w & ~valid_w) != '0)
  `ASSERT_PROP(a_take_onehot, clk_i, rst_ni, $onehot0(take_w))
  `ASSERT_PROP(a_commit_out, clk_i, rst_ni, commit |=> out_valid_q && !pend_q)

endmodule

// ===== tb/sv/sized_block_pool_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// sized_block_pool_allocator_tb
// self-checking bench for the sized block pool allocator: a directed table
// of loads, allocations, releases and unused ops, then randomized rounds
// that fill the table, hand out and free blocks under random sender gaps and
// receiver stalls; results are compared with typed rows or a model of the pool
// ----------------------------------------------------------------------------
module sized_block_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_DEPTH     = 64;
  localparam int DIRECTED_COUNT = 25;
  localparam int RANDOM_ITEMS   = 1725;
  localparam int PHASE_LEN      = 120;
  localparam int DRAIN_CYCLES   = 10;
  localparam logic [sbpa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [sbpa_pkg::ST_W-1:0]   status;
    logic [sbpa_pkg::BASE_W-1:0] offset;
    logic [sbpa_pkg::IDX_W-1:0]  index;
  } alloc_result_t;

  typedef struct packed {
    logic [sbpa_pkg::OP_W-1:0]   op;
    logic [sbpa_pkg::SIZE_W-1:0] size;
    logic [sbpa_pkg::BASE_W-1:0] offset;
    bit                          typed;
    alloc_result_t               result;
  } directed_row_t;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic [sbpa_pkg::OP_W-1:0]   op_i         = '0;
  logic [sbpa_pkg::SIZE_W-1:0] block_size_i = '0;
  logic [sbpa_pkg::BASE_W-1:0] offset_i     = '0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic [sbpa_pkg::ST_W-1:0]   status_o;
  logic [sbpa_pkg::BASE_W-1:0] granted_offset_o;
  logic [sbpa_pkg::IDX_W-1:0]  entry_index_o;

  logic [sbpa_pkg::SIZE_W-1:0] pool_size [POOL_DEPTH];
  logic [sbpa_pkg::BASE_W-1:0] pool_base [POOL_DEPTH];
  bit                          pool_busy [POOL_DEPTH];
  int                          pool_count = 0;

  alloc_result_t pending_results [$];
  int mismatches         = 0;
  int items_sent         = 0;
  int results_checked    = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int status_tally [8];

  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{sbpa_pkg::OP_ALLOC,   16'd5,    22'd0,      1'b1, '{sbpa_pkg::ST_NO_SIZE, 22'd0, 6'd0}},
    '{sbpa_pkg::OP_RELEASE, 16'd0,    22'd0,      1'b1, '{sbpa_pkg::ST_UNKNOWN, 22'd0, 6'd0}},
    '{OP_UNUSED,            16'hffff, 22'h3fffff, 1'b1, '{sbpa_pkg::ST_OK, 22'd0, 6'd0}},
    '{sbpa_pkg::OP_LOAD,    16'hffff, 22'h3fffff, 1'b1, '{sbpa_pkg::ST_OK, 22'd0, 6'd0}},
    '{sbpa_pkg::OP_LOAD,    16'd1,    22'd0,      1'b1, '{sbpa_pkg::ST_OK, 22'd0, 6'd0}},
    '{sbpa_pkg::OP_LOAD,    16'd0,    22'd0,      1'b1, '{sbpa_pkg::ST_OK, 22'd0, 6'd0}},
    '{sbpa_pkg::OP_LOAD,    16'd1,    22'd0,      1'b0, '0},
    '{sbpa_pkg::OP_LOAD,    16'hffff, 22'd0,      1'b0, '0},
    '{sbpa_pkg::OP_ALLOC,   16'd1,    22'd0,      1'b0, '0},
    '{sbpa_pkg::OP_LOAD,    16'd7,    22'd0,      1'b1, '{sbpa_pkg::ST_LOAD_BUSY, 22'd0, 6'd0}},
    '{sbpa_pkg::OP_ALLOC,   16'd1,    22'd0,      1'b0, '0},
    '{sbpa_pkg::OP_ALLOC,   16'd1,    22'd0,      1'b1, '{sbpa_pkg::ST_ALL_BUSY, 22'd0, 6'd0}},
    '{sbpa_pkg::OP_ALLOC,   16'd0,    22'd0,      1'b0, '0},
    '{sbpa_pkg::OP_RELEASE, 16'd0,    22'd0,      1'b0, '0},
    '{sbpa_pkg::OP_RELEASE, 16'd0,    22'd0,      1'b0, '0},
    '{sbpa_pkg::OP_RELEASE, 16'd0,    22'd0,      1'b1, '{sbpa_pkg::ST_UNKNOWN, 22'd0, 6'd0}},
    '{sbpa_pkg::OP_RELEASE, 16'hffff, 22'd1,      1'b0, '0},
    '{sbpa_pkg::OP_ALLOC,   16'd2,    22'd0,      1'b1, '{sbpa_pkg::ST_NO_SIZE, 22'd0, 6'd0}},
    '{sbpa_pkg::OP_ALLOC,   16'hffff, 22'd0,      1'b0, '0},
    '{sbpa_pkg::OP_ALLOC,   16'hffff, 22'd0,      1'b0, '0},
    '{sbpa_pkg::OP_ALLOC,   16'hffff, 22'd0,      1'b1, '{sbpa_pkg::ST_ALL_BUSY, 22'd0, 6'd0}},
    '{sbpa_pkg::OP_RELEASE, 16'd0,    22'd65537,  1'b0, '0},
    '{sbpa_pkg::OP_RELEASE, 16'd0,    22'd2,      1'b0, '0},
    '{sbpa_pkg::OP_RELEASE, 16'd0,    22'h3fffff, 1'b1, '{sbpa_pkg::ST_UNKNOWN, 22'd0, 6'd0}},
    '{OP_UNUSED,            16'd0,    22'd0,      1'b1, '{sbpa_pkg::ST_OK, 22'd0, 6'd0}}
  };

  sized_block_pool_allocator #(
    .MAX_BLOCKS(POOL_DEPTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .block_size_i    (block_size_i),
    .offset_i        (offset_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .granted_offset_o(granted_offset_o),
    .entry_index_o   (entry_index_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic alloc_result_t predict_transaction(
    input logic [sbpa_pkg::OP_W-1:0]   op,
    input logic [sbpa_pkg::SIZE_W-1:0] sz,
    input logic [sbpa_pkg::BASE_W-1:0] off
  );
    alloc_result_t res;
    int pos;
    bit size_seen;
    logic [sbpa_pkg::BASE_W-1:0] acc;
    res = '0;
    size_seen = 1'b0;
    case (op)
      sbpa_pkg::OP_LOAD: begin
        for (int i = 0; i < pool_count; i++) begin
          if (pool_busy[i]) begin
            res.status = sbpa_pkg::ST_LOAD_BUSY;
            return res;
          end
        end
        if (pool_count >= POOL_DEPTH) begin
          res.status = sbpa_pkg::ST_FULL;
          return res;
        end
        pos = 0;
        while (pos < pool_count && pool_size[pos] <= sz) pos++;
        for (int i = pool_count; i > pos; i--) begin
          pool_size[i] = pool_size[i-1];
          pool_busy[i] = pool_busy[i-1];
        end
        pool_size[pos] = sz;
        pool_busy[pos] = 1'b0;
        pool_count++;
        acc = '0;
        for (int i = 0; i < pool_count; i++) begin
          pool_base[i] = acc;
          acc = acc + sbpa_pkg::BASE_W'(pool_size[i]);
        end
        res.status = sbpa_pkg::ST_OK;
        res.offset = pool_base[pos];
        res.index  = sbpa_pkg::IDX_W'(pos);
      end
      sbpa_pkg::OP_ALLOC: begin
        for (int i = 0; i < pool_count; i++) begin
          if (pool_size[i] == sz) begin
            size_seen = 1'b1;
            if (!pool_busy[i]) begin
              pool_busy[i] = 1'b1;
              res.status = sbpa_pkg::ST_OK;
              res.offset = pool_base[i];
              res.index  = sbpa_pkg::IDX_W'(i);
              return res;
            end
          end
        end
        res.status = size_seen ? sbpa_pkg::ST_ALL_BUSY : sbpa_pkg::ST_NO_SIZE;
      end
      sbpa_pkg::OP_RELEASE: begin
        for (int i = 0; i < pool_count; i++) begin
          if (pool_busy[i] && pool_base[i] == off) begin
            pool_busy[i] = 1'b0;
            res.status = sbpa_pkg::ST_OK;
            res.offset = pool_base[i];
            res.index  = sbpa_pkg::IDX_W'(i);
            return res;
          end
        end
        res.status = sbpa_pkg::ST_UNKNOWN;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic int first_busy_entry();
    for (int i = 0; i < pool_count; i++) begin
      if (pool_busy[i]) return i;
    end
    return -1;
  endfunction

  task automatic send_request(input logic [sbpa_pkg::OP_W-1:0] op,
                              input logic [sbpa_pkg::SIZE_W-1:0] sz,
                              input logic [sbpa_pkg::BASE_W-1:0] off, input bit typed,
                              input alloc_result_t typed_res);
    alloc_result_t exp_res;
    int phase;
    if (items_sent < DIRECTED_COUNT) begin
      phase = 0;
    end else begin
      phase = ((items_sent - DIRECTED_COUNT) / PHASE_LEN) % 4;
    end
    sender_idle_pct    = (phase == 1) ? 55 : (phase == 3) ? 20 : 0;
    receiver_stall_pct = (phase == 2) ? 55 : (phase == 3) ? 20 : 0;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    block_size_i <= sz;
    offset_i     <= off;
    do @(posedge clk_i); while (in_stall_o);
    exp_res = predict_transaction(op, sz, off);
    if (typed) exp_res = typed_res;
    status_tally[exp_res.status]++;
    pending_results.insert(pending_results.size(), exp_res);
    items_sent++;
  endtask

  function automatic logic [sbpa_pkg::SIZE_W-1:0] pick_load_size();
    int r;
    r = $urandom_range(99);
    if (r < 40) return sbpa_pkg::SIZE_W'($urandom_range(1, 12));
    if (r < 60 && pool_count > 0) return pool_size[$urandom_range(pool_count - 1)];
    if (r < 85) return sbpa_pkg::SIZE_W'($urandom_range(0, 65535));
    if (r < 95) return ($urandom_range(1) != 0) ? 16'hffff : 16'd1;
    return 16'd0;
  endfunction

  task automatic release_all_busy();
    int idx;
    idx = first_busy_entry();
    while (idx >= 0) begin
      send_request(sbpa_pkg::OP_RELEASE, sbpa_pkg::SIZE_W'($urandom), pool_base[idx],
                   1'b0, '0);
      idx = first_busy_entry();
    end
  endtask

  task automatic random_round();
    int n_loads;
    int n_ops;
    int r;
    int idx;
    logic [sbpa_pkg::SIZE_W-1:0] sz;
    logic [sbpa_pkg::BASE_W-1:0] off;
    if ($urandom_range(1) == 0) release_all_busy();
    n_loads = $urandom_range(1, 4);
    for (int k = 0; k < n_loads; k++) begin
      send_request(sbpa_pkg::OP_LOAD, pick_load_size(), sbpa_pkg::BASE_W'($urandom),
                   1'b0, '0);
    end
    n_ops = $urandom_range(8, 30);
    for (int k = 0; k < n_ops; k++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        if (pool_count > 0 && $urandom_range(99) < 85) begin
          sz = pool_size[$urandom_range(pool_count - 1)];
        end else begin
          sz = sbpa_pkg::SIZE_W'($urandom);
        end
        send_request(sbpa_pkg::OP_ALLOC, sz, sbpa_pkg::BASE_W'($urandom), 1'b0, '0);
      end else if (r < 85) begin
        idx = first_busy_entry();
        if (idx >= 0 && $urandom_range(99) < 80) begin
          idx = $urandom_range(pool_count - 1);
          off = pool_base[idx];
        end else if ($urandom_range(1) == 0) begin
          off = sbpa_pkg::BASE_W'($urandom);
        end else begin
          off = sbpa_pkg::BASE_W'($urandom_range(0, 64));
        end
        send_request(sbpa_pkg::OP_RELEASE, sbpa_pkg::SIZE_W'($urandom), off, 1'b0, '0);
      end else if (r < 95) begin
        send_request(sbpa_pkg::OP_LOAD, pick_load_size(), sbpa_pkg::BASE_W'($urandom),
                     1'b0, '0);
      end else begin
        send_request(OP_UNUSED, sbpa_pkg::SIZE_W'($urandom), sbpa_pkg::BASE_W'($urandom),
                     1'b0, '0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    alloc_result_t exp_res;
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d offset %0d index %0d", $realtime,
                 status_o, granted_offset_o, entry_index_o);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (status_o !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, exp_res.status,
                   status_o);
          mismatches++;
        end
        if (granted_offset_o !== exp_res.offset) begin
          $display("%0t: granted_offset expected %0d actual %0d", $realtime,
                   exp_res.offset, granted_offset_o);
          mismatches++;
        end
        if (entry_index_o !== exp_res.index) begin
          $display("%0t: entry_index expected %0d actual %0d", $realtime, exp_res.index,
                   entry_index_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  initial begin
    foreach (status_tally[i]) status_tally[i] = 0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      pool_size[i] = '0;
      pool_base[i] = '0;
      pool_busy[i] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].size, directed_rows[i].offset,
                   directed_rows[i].typed, directed_rows[i].result);
    end
    while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS) random_round();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) mismatches++;
    $display("checked %0d results of %0d transactions, %0d table entries at the end",
             results_checked, items_sent, pool_count);
    $display("ok %0d, no size %0d, all busy %0d, full %0d, unknown %0d, load busy %0d",
             status_tally[sbpa_pkg::ST_OK], status_tally[sbpa_pkg::ST_NO_SIZE],
             status_tally[sbpa_pkg::ST_ALL_BUSY], status_tally[sbpa_pkg::ST_FULL],
             status_tally[sbpa_pkg::ST_UNKNOWN], status_tally[sbpa_pkg::ST_LOAD_BUSY]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sbpa_pkg.sv
rtl/sbpa_cell.sv
rtl/sized_block_pool_allocator.sv
tb/sv/sized_block_pool_allocator_tb.sv
